// ----- hdl/lr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg: shared types and helpers for the line rasterizer
// Holds the walker state type and the width of a packed line record.
// ----------------------------------------------------------------------------
package lr_pkg;

  typedef enum logic {
    LR_IDLE,
    LR_WALK
  } lr_state_t;

  // A line record is {steep, minor_neg, major_near, minor_near, major_far,
  // minor_span, major_span}: two flags and five coordinate-wide fields.
  function automatic int lr_rec_bits(input int coord_bits);
    return 5 * coord_bits + 2;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/lr_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lr_stream_if: valid/ready channels of the line rasterizer
// One interface carries the line endpoints, the other carries the pixels.
// ----------------------------------------------------------------------------
interface lr_in_if #(
  parameter int W = 6
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] start_x;
  logic [W-1:0] start_y;
  logic [W-1:0] end_x;
  logic [W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_out_if #(
  parameter int W = 6
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] pixel_x;
  logic [W-1:0] pixel_y;
  logic         last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface
`default_nettype wire

// ----- hdl/lr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lr_front: endpoint intake and line classification
// Picks the major axis, orders the endpoints along it and registers the
// resulting line record for the queue.
// ----------------------------------------------------------------------------
module lr_front
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 6,
  parameter int REC_BITS   = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  lr_in_if.sink                    in_ch,
  output logic                     rec_valid,
  output logic [REC_BITS-1:0]      rec_data,
  input  wire logic                rec_ready
);

  localparam int C = COORD_BITS;

  logic                vld_r, vld_nxt;
  logic [REC_BITS-1:0] rec_r, rec_nxt;

  logic [C-1:0] adx, ady;
  logic         steep;
  logic [C-1:0] a0, b0, a1, b1;
  logic [C-1:0] ag, bg, ad, bd;
  logic [C-1:0] dmaj, dmin;
  logic         neg;
  logic         accept;

  assign in_ch.ready = !vld_r || rec_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    adx = (in_ch.end_x > in_ch.start_x) ? in_ch.end_x - in_ch.start_x
                                        : in_ch.start_x - in_ch.end_x;
    ady = (in_ch.end_y > in_ch.start_y) ? in_ch.end_y - in_ch.start_y
                                        : in_ch.start_y - in_ch.end_y;
    // Equal spans keep x as the major axis.
    steep = ady > adx;
    if (steep) begin
      a0 = in_ch.start_y; b0 = in_ch.start_x;
      a1 = in_ch.end_y;   b1 = in_ch.end_x;
    end else begin
      a0 = in_ch.start_x; b0 = in_ch.start_y;
      a1 = in_ch.end_x;   b1 = in_ch.end_y;
    end
    if (a0 < a1) begin
      ag = a0; bg = b0; ad = a1; bd = b1;
    end else begin
      ag = a1; bg = b1; ad = a0; bd = b0;
    end
    dmaj = ad - ag;
    neg  = bd < bg;
    dmin = neg ? bg - bd : bd - bg;
  end

  always_comb begin
    vld_nxt = vld_r;
    rec_nxt = rec_r;
    if (accept) begin
      vld_nxt = 1'b1;
      rec_nxt = {steep, neg, ag, bg, ad, dmin, dmaj};
    end else if (rec_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    rec_r <= rec_nxt;
  end

  assign rec_valid = vld_r;
  assign rec_data  = rec_r;

endmodule
`default_nettype wire

// ----- hdl/lr_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lr_queue: two-entry line record queue
// Decouples line classification from the pixel walk.
// ----------------------------------------------------------------------------
module lr_queue
  import lr_pkg::*;
#(
  parameter int REC_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  input  wire logic [REC_BITS-1:0] push_data,
  output logic                     push_ready,
  output logic                     pop_valid,
  output logic [REC_BITS-1:0]      pop_data,
  input  wire logic                pop
);

  localparam int DEPTH = 2;

  logic [REC_BITS-1:0] slot_r [DEPTH];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign push_ready = cnt_r != 2'(DEPTH);
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lr_walker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lr_walker: Bresenham pixel walk
// Steps one pixel per cycle along the major axis into a registered output while the output is not stalled.
// ----------------------------------------------------------------------------
module lr_walker
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 6,
  parameter int REC_BITS   = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rec_valid,
  input  wire logic [REC_BITS-1:0] rec_data,
  output logic                     rec_pop,
  lr_out_if.source                 out_ch
);

  localparam int C  = COORD_BITS;
  localparam int EW = C + 2;

  lr_state_t state_r, state_nxt;

  logic [C-1:0]         a_r, a_nxt;
  logic [C-1:0]         b_r, b_nxt;
  logic [C-1:0]         ad_r, ad_nxt;
  logic [C-1:0]         dmin_r, dmin_nxt;
  logic [C-1:0]         dmaj_r, dmaj_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic                 steep_r, steep_nxt;
  logic                 neg_r, neg_nxt;

  logic                 ovld_r, ovld_nxt;
  logic [C-1:0]         px_r, px_nxt;
  logic [C-1:0]         py_r, py_nxt;
  logic                 last_r, last_nxt;

  logic                 r_steep, r_neg;
  logic [C-1:0]         r_ag, r_bg, r_ad, r_dmin, r_dmaj;
  logic                 load;
  logic signed [EW-1:0] two_dmin, two_dmaj;

  assign r_dmaj  = rec_data[C-1:0];
  assign r_dmin  = rec_data[2*C-1:C];
  assign r_ad    = rec_data[3*C-1:2*C];
  assign r_bg    = rec_data[4*C-1:3*C];
  assign r_ag    = rec_data[5*C-1:4*C];
  assign r_neg   = rec_data[5*C];
  assign r_steep = rec_data[5*C+1];

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ad_nxt    = ad_r;
    dmin_nxt  = dmin_r;
    dmaj_nxt  = dmaj_r;
    err_nxt   = err_r;
    steep_nxt = steep_r;
    neg_nxt   = neg_r;
    ovld_nxt  = ovld_r && !out_ch.ready;
    px_nxt    = px_r;
    py_nxt    = py_r;
    last_nxt  = last_r;
    rec_pop   = 1'b0;
    load      = 1'b0;
    two_dmin  = $signed({1'b0, dmin_r, 1'b0});
    two_dmaj  = $signed({1'b0, dmaj_r, 1'b0});

    case (state_r)
      LR_IDLE: begin
        if (rec_valid) begin
          rec_pop   = 1'b1;
          a_nxt     = r_ag;
          b_nxt     = r_bg;
          ad_nxt    = r_ad;
          dmin_nxt  = r_dmin;
          dmaj_nxt  = r_dmaj;
          steep_nxt = r_steep;
          neg_nxt   = r_neg;
          err_nxt   = $signed({1'b0, r_dmin, 1'b0}) - $signed({2'b00, r_dmaj});
          state_nxt = LR_WALK;
        end
      end
      LR_WALK: begin
        load = !ovld_r || out_ch.ready;
        if (load) begin
          ovld_nxt = 1'b1;
          px_nxt   = steep_r ? b_r : a_r;
          py_nxt   = steep_r ? a_r : b_r;
          last_nxt = a_r == ad_r;
          a_nxt    = a_r + C'(1);
          // The error term stays within its width after the update, so any
          // wrap in the intermediate sum cancels out.
          if (err_r > 0) begin
            b_nxt   = neg_r ? b_r - C'(1) : b_r + C'(1);
            err_nxt = err_r + two_dmin - two_dmaj;
          end else begin
            err_nxt = err_r + two_dmin;
          end
          if (a_r == ad_r) begin
            state_nxt = LR_IDLE;
          end
        end
      end
      default: begin
        state_nxt = LR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LR_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    ad_r    <= ad_nxt;
    dmin_r  <= dmin_nxt;
    dmaj_r  <= dmaj_nxt;
    err_r   <= err_nxt;
    steep_r <= steep_nxt;
    neg_r   <= neg_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid      = ovld_r;
  assign out_ch.pixel_x    = px_r;
  assign out_ch.pixel_y    = py_r;
  assign out_ch.last_pixel = last_r;

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rec_pop |-> state_r == LR_IDLE)
    else $error("line record taken while a walk is in progress");

  a_pop_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rec_pop |=> state_r == LR_WALK)
    else $error("line record taken without starting a walk");

  a_major_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == LR_WALK |-> a_r <= ad_r)
    else $error("walk ran past the far endpoint");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (load && a_r == ad_r) |=> (state_r == LR_IDLE && ovld_r && last_r))
    else $error("final pixel did not end the walk");
`endif

endmodule
`default_nettype wire

// ----- hdl/line_rasterizer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer_top: Bresenham line rasterizer
// Turns a pair of endpoints into the stream of pixels of the line between them.
// ----------------------------------------------------------------------------
// Each accepted item is one line; it produces dmajor + 1 pixel items, where
// dmajor is the larger of the x and y spans, in increasing order of the major
// coordinate, and the final one carries last_pixel. The pixel walker emits one
// pixel per cycle while the output is not stalled and passes through its idle
// state to fetch the next line record from the queue between lines.
// The front end classifies a line into a registered record and a two-entry
// queue lets up to three further lines be accepted while one is being walked.
// Coordinates are COORD_BITS wide; there are no configuration registers.
module line_rasterizer_top
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lr_in_if.sink     in_ch,
  lr_out_if.source  out_ch
);

  localparam int REC_BITS = lr_rec_bits(COORD_BITS);

  logic                f_valid, f_ready;
  logic [REC_BITS-1:0] f_data;
  logic                q_valid, q_pop;
  logic [REC_BITS-1:0] q_data;

  lr_front #(
    .COORD_BITS (COORD_BITS),
    .REC_BITS   (REC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .rec_valid (f_valid),
    .rec_data  (f_data),
    .rec_ready (f_ready)
  );

  lr_queue #(
    .REC_BITS (REC_BITS)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_data  (f_data),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  lr_walker #(
    .COORD_BITS (COORD_BITS),
    .REC_BITS   (REC_BITS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (q_valid),
    .rec_data  (q_data),
    .rec_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
